// File: design/sm83_opcode_row0_execute_macros.svh
// assertion macros for the sm83 row 0 executor
`ifndef SM83_OPCODE_ROW0_EXECUTE_MACROS_SVH
`define SM83_OPCODE_ROW0_EXECUTE_MACROS_SVH

// same-cycle implication
`define SM83_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm83 same-cycle check failed");

// next-cycle implication
`define SM83_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm83 next-cycle check failed");

`endif

// File: design/sm83_pkg.sv
// shared types and constants for the sm83 row 0 executor
package sm83_pkg;

  localparam int unsigned AddrBits  = 16;
  localparam int unsigned MemDepth  = 1 << AddrBits;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrBits  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntBits  = $clog2(QDepth + 1);

  localparam logic [15:0] SpReset = 16'hFFFE;

  localparam logic [4:0] Cyc4  = 5'd4;
  localparam logic [4:0] Cyc8  = 5'd8;
  localparam logic [4:0] Cyc12 = 5'd12;
  localparam logic [4:0] Cyc20 = 5'd20;

  typedef logic [AddrBits-1:0] addr_t;

  typedef enum logic [3:0] {
    OP_NOP          = 4'h0,
    OP_LD_BC_IMM16  = 4'h1,
    OP_LD_MBC_A     = 4'h2,
    OP_INCW_BC      = 4'h3,
    OP_INCR_B       = 4'h4,
    OP_DECR_B       = 4'h5,
    OP_LD_B_IMM     = 4'h6,
    OP_RLCA         = 4'h7,
    OP_LD_MA16_SP   = 4'h8,
    OP_ADDW_HL      = 4'h9,
    OP_LD_A_MBC     = 4'hA,
    OP_DECW_BC      = 4'hB,
    OP_INCR_C       = 4'hC,
    OP_DECR_C       = 4'hD,
    OP_LD_C_IMM     = 4'hE,
    OP_RRCA         = 4'hF
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_WR_HI,
    BK_RD_WAIT
  } bk_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [4:0] cyc;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t uop;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_status_t;

endpackage

// File: design/sm83_front.sv
// front end: request intake, opcode classification and the issue queue
module sm83_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              command_i,
  input  logic [7:0]              imm_lo_i,
  input  logic [7:0]              imm_hi_i,
  input  sm83_pkg::bk_status_t    status_i,
  output sm83_pkg::fq_t           fq_o
);

  sm83_pkg::uop_t                    dec_uop;
  sm83_pkg::uop_t                    q_mem_q [sm83_pkg::QDepth];
  logic [sm83_pkg::QPtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sm83_pkg::QPtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sm83_pkg::QCntBits-1:0]     cnt_q, cnt_d;
  logic                              full, push, pop;

  always_comb begin
    dec_uop.op = sm83_pkg::op_e'(command_i);
    dec_uop.lo = imm_lo_i;
    dec_uop.hi = imm_hi_i;
    case (dec_uop.op)
      sm83_pkg::OP_LD_BC_IMM16: dec_uop.cyc = sm83_pkg::Cyc12;
      sm83_pkg::OP_LD_MA16_SP:  dec_uop.cyc = sm83_pkg::Cyc20;
      sm83_pkg::OP_LD_MBC_A, sm83_pkg::OP_INCW_BC, sm83_pkg::OP_LD_B_IMM,
      sm83_pkg::OP_ADDW_HL, sm83_pkg::OP_LD_A_MBC, sm83_pkg::OP_DECW_BC,
      sm83_pkg::OP_LD_C_IMM:    dec_uop.cyc = sm83_pkg::Cyc8;
      default:                  dec_uop.cyc = sm83_pkg::Cyc4;
    endcase
  end

  assign full       = (cnt_q == sm83_pkg::QCntBits'(sm83_pkg::QDepth));
  assign in_stall_o = full | status_i.clearing;
  assign push       = in_valid_i & ~in_stall_o;
  assign pop        = status_i.pop;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == sm83_pkg::QPtrBits'(sm83_pkg::QDepth - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == sm83_pkg::QPtrBits'(sm83_pkg::QDepth - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + sm83_pkg::QCntBits'(push) - sm83_pkg::QCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= dec_uop;
    end
  end

  assign fq_o.valid = (cnt_q != '0);
  assign fq_o.uop   = q_mem_q[rd_ptr_q];

endmodule

// File: design/sm83_back.sv
// back end: register file, byte memory, execution and result register
module sm83_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [15:0]          cfg_data_i,
  input  sm83_pkg::fq_t        fq_i,
  output sm83_pkg::bk_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_a_o,
  output logic [7:0]           out_b_o,
  output logic [7:0]           out_c_o,
  output logic [7:0]           out_h_o,
  output logic [7:0]           out_l_o,
  output logic [3:0]           flag_bits_o,
  output logic [4:0]           cycle_count_o
);

  sm83_pkg::bk_state_e state_q, state_d;
  sm83_pkg::addr_t     clr_q, clr_d;
  sm83_pkg::addr_t     hi_addr_q, hi_addr_d;
  sm83_pkg::addr_t     mem_addr;
  logic [7:0]          mem_q [sm83_pkg::MemDepth];
  logic [7:0]          rd_q, mem_wdata;
  logic                mem_we, mem_re;

  logic [15:0] sp_q;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, h_q, h_d, l_q, l_d;
  logic [3:0]  f_q, f_d;

  logic        out_valid_q, out_load;
  logic [7:0]  out_a_q, out_b_q, out_c_q, out_h_q, out_l_q;
  logic [3:0]  out_f_q;
  logic [4:0]  out_cyc_q, cyc_d;

  logic        slot_free, issue;
  logic [15:0] bc, hl, bc_inc, bc_dec, a16, a16_nx;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  sm83_pkg::uop_t uop;

  assign uop       = fq_i.uop;
  assign bc        = {b_q, c_q};
  assign hl        = {h_q, l_q};
  assign bc_inc    = bc + 16'd1;
  assign bc_dec    = bc - 16'd1;
  assign a16       = {uop.hi, uop.lo};
  assign a16_nx    = a16 + 16'd1;
  assign hl_sum    = {1'b0, hl} + {1'b0, bc};
  assign hl_half   = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign issue     = (state_q == sm83_pkg::BK_RUN) & fq_i.valid & slot_free;

  assign status_o.pop      = issue;
  assign status_o.clearing = (state_q == sm83_pkg::BK_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sm83_pkg::BK_CLEAR: begin
        if (clr_q == '1) state_d = sm83_pkg::BK_RUN;
      end
      sm83_pkg::BK_RUN: begin
        if (issue && uop.op == sm83_pkg::OP_LD_MA16_SP) state_d = sm83_pkg::BK_WR_HI;
        if (issue && uop.op == sm83_pkg::OP_LD_A_MBC)   state_d = sm83_pkg::BK_RD_WAIT;
      end
      sm83_pkg::BK_WR_HI:   state_d = sm83_pkg::BK_RUN;
      sm83_pkg::BK_RD_WAIT: begin
        if (slot_free) state_d = sm83_pkg::BK_RUN;
      end
      default:              state_d = sm83_pkg::BK_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    h_d       = h_q;
    l_d       = l_q;
    f_d       = f_q;
    cyc_d     = uop.cyc;
    clr_d     = clr_q;
    hi_addr_d = hi_addr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = clr_q;
    mem_wdata = '0;
    out_load  = 1'b0;
    case (state_q)
      sm83_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      sm83_pkg::BK_RUN: begin
        if (issue) begin
          out_load = (uop.op != sm83_pkg::OP_LD_A_MBC);
          case (uop.op)
            sm83_pkg::OP_NOP: ;
            sm83_pkg::OP_LD_BC_IMM16: begin
              b_d = uop.hi;
              c_d = uop.lo;
            end
            sm83_pkg::OP_LD_MBC_A: begin
              mem_we    = 1'b1;
              mem_addr  = bc[sm83_pkg::AddrBits-1:0];
              mem_wdata = a_q;
            end
            sm83_pkg::OP_INCW_BC: {b_d, c_d} = bc_inc;
            sm83_pkg::OP_INCR_B: begin
              b_d = b_q + 8'd1;
              f_d = {b_d == 8'd0, 1'b0, b_q[3:0] == 4'hF, f_q[0]};
            end
            sm83_pkg::OP_DECR_B: begin
              b_d = b_q - 8'd1;
              f_d = {b_d == 8'd0, 1'b1, b_q[3:0] == 4'h0, f_q[0]};
            end
            sm83_pkg::OP_LD_B_IMM: b_d = uop.lo;
            sm83_pkg::OP_RLCA: begin
              a_d = {a_q[6:0], a_q[7]};
              f_d = {3'b000, a_q[7]};
            end
            sm83_pkg::OP_LD_MA16_SP: begin
              mem_we    = 1'b1;
              mem_addr  = a16[sm83_pkg::AddrBits-1:0];
              mem_wdata = sp_q[7:0];
              hi_addr_d = a16_nx[sm83_pkg::AddrBits-1:0];
            end
            sm83_pkg::OP_ADDW_HL: begin
              {h_d, l_d} = hl_sum[15:0];
              f_d        = {f_q[3], 1'b0, hl_half[12], hl_sum[16]};
            end
            sm83_pkg::OP_LD_A_MBC: begin
              mem_re   = 1'b1;
              mem_addr = bc[sm83_pkg::AddrBits-1:0];
            end
            sm83_pkg::OP_DECW_BC: {b_d, c_d} = bc_dec;
            sm83_pkg::OP_INCR_C: begin
              c_d = c_q + 8'd1;
              f_d = {c_d == 8'd0, 1'b0, c_q[3:0] == 4'hF, f_q[0]};
            end
            sm83_pkg::OP_DECR_C: begin
              c_d = c_q - 8'd1;
              f_d = {c_d == 8'd0, 1'b1, c_q[3:0] == 4'h0, f_q[0]};
            end
            sm83_pkg::OP_LD_C_IMM: c_d = uop.lo;
            default: begin
              a_d = {a_q[0], a_q[7:1]};
              f_d = {3'b000, a_q[0]};
            end
          endcase
        end
      end
      sm83_pkg::BK_WR_HI: begin
        mem_we    = 1'b1;
        mem_addr  = hi_addr_q;
        mem_wdata = sp_q[15:8];
      end
      sm83_pkg::BK_RD_WAIT: begin
        cyc_d = sm83_pkg::Cyc8;
        if (slot_free) begin
          a_d      = rd_q;
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sm83_pkg::BK_CLEAR;
      clr_q       <= '0;
      sp_q        <= sm83_pkg::SpReset;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      h_q         <= '0;
      l_q         <= '0;
      f_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      if (cfg_valid_i) sp_q <= cfg_data_i;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      h_q         <= h_d;
      l_q         <= l_d;
      f_q         <= f_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    hi_addr_q <= hi_addr_d;
    if (out_load) begin
      out_a_q   <= a_d;
      out_b_q   <= b_d;
      out_c_q   <= c_d;
      out_h_q   <= h_d;
      out_l_q   <= l_d;
      out_f_q   <= f_d;
      out_cyc_q <= cyc_d;
    end
  end

  // single-port byte memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_a_o       = out_a_q;
  assign out_b_o       = out_b_q;
  assign out_c_o       = out_c_q;
  assign out_h_o       = out_h_q;
  assign out_l_o       = out_l_q;
  assign flag_bits_o   = out_f_q;
  assign cycle_count_o = out_cyc_q;

endmodule

// File: design/sm83_opcode_row0_execute.sv
// top level of the sm83 opcode row 0 executor
// a request is queued, issued when the back end runs and the output slot is free, and
// registered; throughput: one request per cycle unless the queue is full, the memory clears
//   or the output stalls; LD (a16),SP and LD A,(BC) hold the back end an extra state, set
//   by the single port and the registered read of the byte memory; reset: registers and flags
//   clear at once; a clearing pass then zeroes the memory with the input stalled, configuration writes still taken
`include "sm83_opcode_row0_execute_macros.svh"

module sm83_opcode_row0_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  imm_lo_i,
  input  logic [7:0]  imm_hi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_a_o,
  output logic [7:0]  out_b_o,
  output logic [7:0]  out_c_o,
  output logic [7:0]  out_h_o,
  output logic [7:0]  out_l_o,
  output logic [3:0]  flag_bits_o,
  output logic [4:0]  cycle_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  sm83_pkg::fq_t        fq;
  sm83_pkg::bk_status_t status;
  logic                 store_sp_issue, cyc_legal;

  assign cfg_ready_o = 1'b1;

  sm83_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .imm_lo_i   (imm_lo_i),
    .imm_hi_i   (imm_hi_i),
    .status_i   (status),
    .fq_o       (fq)
  );

  sm83_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fq_i          (fq),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_a_o       (out_a_o),
    .out_b_o       (out_b_o),
    .out_c_o       (out_c_o),
    .out_h_o       (out_h_o),
    .out_l_o       (out_l_o),
    .flag_bits_o   (flag_bits_o),
    .cycle_count_o (cycle_count_o)
  );

  assign store_sp_issue = status.pop & (fq.uop.op == sm83_pkg::OP_LD_MA16_SP);
  assign cyc_legal      = cycle_count_o inside {sm83_pkg::Cyc4, sm83_pkg::Cyc8,
                                                sm83_pkg::Cyc12, sm83_pkg::Cyc20};

  `SM83_ASSERT_IMP(a_no_take_while_clearing, status.clearing, in_stall_o)
  `SM83_ASSERT_IMP(a_pop_needs_entry, status.pop, fq.valid && !status.clearing)
  `SM83_ASSERT_NXT(a_store_sp_holds_issue, store_sp_issue, !status.pop)
  `SM83_ASSERT_IMP(a_cycle_count_legal, out_valid_o, cyc_legal)

endmodule

// File: sim/tb_sm83_opcode_row0_execute.sv
// testbench for the sm83 opcode row 0 executor, checked against a shadow cpu
`timescale 1ns / 100ps

module tb_sm83_opcode_row0_execute;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] h;
    logic [7:0] l;
    logic [3:0] flags;
    logic [4:0] cycles;
  } regs_t;

  // shadow copy of the cpu state and the register values still owed by the block
  class cpu_shadow;
    logic [7:0]  acc, reg_b, reg_c, reg_h, reg_l;
    logic [3:0]  flags;
    logic [15:0] sp;
    logic [7:0]  mem [sm83_pkg::MemDepth];
    regs_t       pending[$];
    int          failures;

    function new();
      acc      = '0;
      reg_b    = '0;
      reg_c    = '0;
      reg_h    = '0;
      reg_l    = '0;
      flags    = '0;
      sp       = sm83_pkg::SpReset;
      failures = 0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    // flags are {z, n, h, c}
    function logic [7:0] incr8(logic [7:0] v);
      logic [7:0] r;
      r     = v + 8'd1;
      flags = {r == 8'd0, 1'b0, v[3:0] == 4'hF, flags[0]};
      return r;
    endfunction

    function logic [7:0] decr8(logic [7:0] v);
      logic [7:0] r;
      r     = v - 8'd1;
      flags = {r == 8'd0, 1'b1, v[3:0] == 4'h0, flags[0]};
      return r;
    endfunction

    function void execute(sm83_pkg::op_e op, logic [7:0] lo, logic [7:0] hi);
      logic [15:0] bc, hl, addr;
      logic [16:0] sum;
      logic [12:0] low12;
      regs_t       r;
      bc       = {reg_b, reg_c};
      hl       = {reg_h, reg_l};
      addr     = {hi, lo};
      r.cycles = sm83_pkg::Cyc4;
      case (op)
        sm83_pkg::OP_NOP: ;
        sm83_pkg::OP_LD_BC_IMM16: begin
          reg_b    = hi;
          reg_c    = lo;
          r.cycles = sm83_pkg::Cyc12;
        end
        sm83_pkg::OP_LD_MBC_A: begin
          mem[bc]  = acc;
          r.cycles = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_INCW_BC: begin
          {reg_b, reg_c} = bc + 16'd1;
          r.cycles       = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_INCR_B: reg_b = incr8(reg_b);
        sm83_pkg::OP_DECR_B: reg_b = decr8(reg_b);
        sm83_pkg::OP_LD_B_IMM: begin
          reg_b    = lo;
          r.cycles = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_RLCA: begin
          acc   = {acc[6:0], acc[7]};
          flags = {3'b000, acc[0]};
        end
        sm83_pkg::OP_LD_MA16_SP: begin
          mem[addr]         = sp[7:0];
          mem[addr + 16'd1] = sp[15:8];
          r.cycles          = sm83_pkg::Cyc20;
        end
        sm83_pkg::OP_ADDW_HL: begin
          sum            = {1'b0, hl} + {1'b0, bc};
          low12          = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
          flags          = {flags[3], 1'b0, low12[12], sum[16]};
          {reg_h, reg_l} = sum[15:0];
          r.cycles       = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_LD_A_MBC: begin
          acc      = mem[bc];
          r.cycles = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_DECW_BC: begin
          {reg_b, reg_c} = bc - 16'd1;
          r.cycles       = sm83_pkg::Cyc8;
        end
        sm83_pkg::OP_INCR_C: reg_c = incr8(reg_c);
        sm83_pkg::OP_DECR_C: reg_c = decr8(reg_c);
        sm83_pkg::OP_LD_C_IMM: begin
          reg_c    = lo;
          r.cycles = sm83_pkg::Cyc8;
        end
        default: begin
          acc   = {acc[0], acc[7:1]};
          flags = {3'b000, acc[7]};
        end
      endcase
      r.a     = acc;
      r.b     = reg_b;
      r.c     = reg_c;
      r.h     = reg_h;
      r.l     = reg_l;
      r.flags = flags;
      pending.push_back(r);
    endfunction

    function void check_state(regs_t got);
      regs_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result a=%h b=%h c=%h h=%h l=%h f=%b cyc=%0d",
                   got.a, got.b, got.c, got.h, got.l, got.flags, got.cycles);
        return;
      end
      want = pending.pop_front();
      if (got.a !== want.a || got.b !== want.b || got.c !== want.c || got.h !== want.h ||
          got.l !== want.l || got.flags !== want.flags || got.cycles !== want.cycles) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected a=%h b=%h c=%h h=%h l=%h f=%b cyc=%0d",
                   want.a, want.b, want.c, want.h, want.l, want.flags, want.cycles);
          $display("          got      a=%h b=%h c=%h h=%h l=%h f=%b cyc=%0d",
                   got.a, got.b, got.c, got.h, got.l, got.flags, got.cycles);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [3:0]  command_i     = '0;
  logic [7:0]  imm_lo_i      = '0;
  logic [7:0]  imm_hi_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  out_a_o, out_b_o, out_c_o, out_h_o, out_l_o;
  logic [3:0]  flag_bits_o;
  logic [4:0]  cycle_count_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;

  cpu_shadow shadow;

  sm83_opcode_row0_execute i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .imm_lo_i      (imm_lo_i),
    .imm_hi_i      (imm_hi_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_a_o       (out_a_o),
    .out_b_o       (out_b_o),
    .out_c_o       (out_c_o),
    .out_h_o       (out_h_o),
    .out_l_o       (out_l_o),
    .flag_bits_o   (flag_bits_o),
    .cycle_count_o (cycle_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_stall_i = 1'b1;
        hold_len--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.check_state({out_a_o, out_b_o, out_c_o, out_h_o, out_l_o,
                          flag_bits_o, cycle_count_o});
  end

  task automatic send_request(input sm83_pkg::op_e op, input logic [7:0] lo,
                              input logic [7:0] hi);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i  = op;
    imm_lo_i   = lo;
    imm_hi_i   = hi;
    do @(posedge clk_i); while (in_stall_o);
    shadow.execute(op, lo, hi);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_stack_pointer(input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.sp = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // addresses cluster so that reads hit bytes written earlier, wrap included
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(4))
      0:       return 16'h0000 + 16'($urandom_range(3));
      1:       return 16'hFFFC + 16'($urandom_range(3));
      2:       return 16'h1230 + 16'($urandom_range(7));
      3:       return 16'h00FE + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count, input bit with_hold);
    logic [15:0]   addr;
    sm83_pkg::op_e op;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      if (with_hold && n == 100) hold_len = 400;
      op   = sm83_pkg::op_e'($urandom_range(15));
      addr = pick_addr();
      if ($urandom_range(7) == 0) begin
        send_request(sm83_pkg::OP_LD_BC_IMM16, addr[7:0], addr[15:8]);
        op   = $urandom_range(1) ? sm83_pkg::OP_LD_A_MBC : sm83_pkg::OP_LD_MBC_A;
        addr = pick_addr();
      end
      if (op == sm83_pkg::OP_LD_BC_IMM16 || op == sm83_pkg::OP_LD_MA16_SP)
        send_request(op, addr[7:0], addr[15:8]);
      else
        send_request(op, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    shadow = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // taken during the memory clearing pass
    set_stack_pointer(16'h80FF);

    // unused operands, register wrap at both ends, half and full carries
    send_request(sm83_pkg::OP_NOP,         8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_B_IMM,    8'hFF, 8'h00);
    send_request(sm83_pkg::OP_LD_C_IMM,    8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_INCR_B,      8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_DECR_B,      8'h00, 8'h00);
    send_request(sm83_pkg::OP_INCR_C,      8'h00, 8'hFF);
    send_request(sm83_pkg::OP_DECR_C,      8'hFF, 8'h00);
    send_request(sm83_pkg::OP_INCW_BC,     8'h00, 8'h00);
    send_request(sm83_pkg::OP_DECW_BC,     8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_BC_IMM16, 8'hFF, 8'h0F);
    send_request(sm83_pkg::OP_ADDW_HL,     8'h00, 8'h00);
    send_request(sm83_pkg::OP_ADDW_HL,     8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_BC_IMM16, 8'h00, 8'hF0);
    send_request(sm83_pkg::OP_ADDW_HL,     8'h00, 8'h00);
    // second byte wraps to address zero
    send_request(sm83_pkg::OP_LD_MA16_SP,  8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_BC_IMM16, 8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_A_MBC,    8'h00, 8'h00);
    send_request(sm83_pkg::OP_LD_BC_IMM16, 8'h00, 8'h00);
    send_request(sm83_pkg::OP_LD_A_MBC,    8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_RLCA,        8'h00, 8'h00);
    send_request(sm83_pkg::OP_RRCA,        8'h00, 8'h00);
    send_request(sm83_pkg::OP_RRCA,        8'hFF, 8'hFF);
    send_request(sm83_pkg::OP_LD_MBC_A,    8'h00, 8'h00);
    send_request(sm83_pkg::OP_LD_A_MBC,    8'h00, 8'h00);
    wait_drained();

    set_stack_pointer(16'h0000);
    send_idle_pct = 7;
    recv_idle_pct = 82;
    send_random(440, 1'b0);
    wait_drained();

    set_stack_pointer(16'hFFFF);
    send_idle_pct = 82;
    recv_idle_pct = 7;
    send_random(440, 1'b0);
    wait_drained();

    set_stack_pointer(16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(440, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (shadow.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
